// ----- sv/itoar_pkg.sv -----
// ----------------------------------------------------------------------------
// itoar_pkg
// Shared types, character constants and helpers for the integer-to-ASCII
// radix converter.
// ----------------------------------------------------------------------------
package itoar_pkg;

  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned ACTION_W       = 3;
  localparam int unsigned CHAR_W         = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] UPPER_GAP   = 7'd7;
  localparam logic [CHAR_W-1:0] LOWER_GAP   = 7'd39;

  typedef enum logic [ACTION_W-1:0] {
    FMT_DEC    = 3'd0,
    FMT_HEX_UP = 3'd1,
    FMT_HEX_LO = 3'd2,
    FMT_OCT    = 3'd3,
    FMT_BIN    = 3'd4
  } fmt_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_SHIFT
  } op_e;

  typedef struct packed {
    op_e  op;
    fmt_e fmt;
  } ctrl_t;

  // Decimal digits needed for a word of the given width (1233/4096 ~ log10 2)
  function automatic int unsigned dec_digits(input int unsigned width);
    return ((width * 1233) >> 12) + 1;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input fmt_e fmt);
    logic [CHAR_W-1:0] c;
    c = ASCII_ZERO + CHAR_W'(d);
    if (d > 4'd9) begin
      if (fmt == FMT_HEX_LO) begin
        c = c + LOWER_GAP;
      end else begin
        c = c + UPPER_GAP;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/itoar_shifter.sv -----
// ----------------------------------------------------------------------------
// itoar_shifter
// Digit register with one shared step unit: load, double-dabble step for
// decimal, or shift out one digit of the selected radix.
// ----------------------------------------------------------------------------
module itoar_shifter #(
  parameter int unsigned WORD_WIDTH = itoar_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  itoar_pkg::ctrl_t      ctrl_i,
  input  logic [WORD_WIDTH-1:0] value_i,
  output logic [3:0]            top_digit_o
);

  localparam int unsigned NDEC   = itoar_pkg::dec_digits(WORD_WIDTH);
  localparam int unsigned WK     = 4 * NDEC;
  localparam int unsigned ND_HEX = (WORD_WIDTH + 3) / 4;
  localparam int unsigned ND_OCT = (WORD_WIDTH + 2) / 3;
  localparam int unsigned SH_HEX = WK - 4 * ND_HEX;
  localparam int unsigned SH_OCT = WK - 3 * ND_OCT;
  localparam int unsigned SH_BIN = WK - WORD_WIDTH;

  logic [WK-1:0]         dig_q, dig_d;
  logic [WK-1:0]         adj;
  logic [WORD_WIDTH-1:0] mag_q, mag_d;

  // add 3 to every BCD digit of 5 or more ahead of the shift
  always_comb begin
    logic [3:0] nib;
    nib = '0;
    for (int i = 0; i < NDEC; i++) begin
      nib = dig_q[4*i +: 4];
      adj[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
  end

  always_comb begin
    dig_d = dig_q;
    mag_d = mag_q;
    case (ctrl_i.op)
      itoar_pkg::OP_LOAD: begin
        case (ctrl_i.fmt)
          itoar_pkg::FMT_DEC: begin
            mag_d = value_i[WORD_WIDTH-1] ? (~value_i + 1'b1) : value_i;
            dig_d = '0;
          end
          itoar_pkg::FMT_HEX_UP, itoar_pkg::FMT_HEX_LO: dig_d = WK'(value_i) << SH_HEX;
          itoar_pkg::FMT_OCT: dig_d = WK'(value_i) << SH_OCT;
          default:            dig_d = WK'(value_i) << SH_BIN;
        endcase
      end
      itoar_pkg::OP_DABBLE: begin
        dig_d = {adj[WK-2:0], mag_q[WORD_WIDTH-1]};
        mag_d = mag_q << 1;
      end
      itoar_pkg::OP_SHIFT: begin
        case (ctrl_i.fmt)
          itoar_pkg::FMT_OCT: dig_d = dig_q << 3;
          itoar_pkg::FMT_BIN: dig_d = dig_q << 1;
          default:            dig_d = dig_q << 4;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    mag_q <= mag_d;
  end

  always_comb begin
    case (ctrl_i.fmt)
      itoar_pkg::FMT_OCT: top_digit_o = {1'b0, dig_q[WK-1 -: 3]};
      itoar_pkg::FMT_BIN: top_digit_o = {3'b000, dig_q[WK-1]};
      default:            top_digit_o = dig_q[WK-1 -: 4];
    endcase
  end

endmodule

// ----- sv/integer_to_ascii_radix.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one word to its ASCII digits (signed decimal, hex upper/lower,
// octal or binary), most significant first, with tlast on the final one.
// ----------------------------------------------------------------------------
// One word is taken per conversion and the input stays not ready until its
// last character has been loaded into the output register. For decimal, the
// accepted word goes through WORD_WIDTH double-dabble steps, then up to NDEC-1
// leading zeros are skipped, a '-' is emitted for a negative word and one
// character is emitted per printed digit (skips and digits together always
// make NDEC). Hex, octal and binary go straight from the accept to up to N-1
// leading-zero skips and then one character per printed digit (together
// always N, the digit count of the radix). All of this runs through one
// shared digit register, which holds while the output is stalled.
// Selector codes 5 to 7 are taken and dropped with no output.
module integer_to_ascii_radix #(
  parameter int unsigned WORD_WIDTH = itoar_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [2:0] action, [WORD_WIDTH+2:3] value, zero pad above
  input  logic [((itoar_pkg::ACTION_W + WORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [6:0] char_code, [7] zero pad
  output logic [7:0]            m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  localparam int unsigned NDEC   = itoar_pkg::dec_digits(WORD_WIDTH);
  localparam int unsigned WK     = 4 * NDEC;
  localparam int unsigned CNT_W  = $clog2(WK + 1);
  localparam int unsigned ND_HEX = (WORD_WIDTH + 3) / 4;
  localparam int unsigned ND_OCT = (WORD_WIDTH + 2) / 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e                          state_q;
  itoar_pkg::fmt_e                 fmt_q;
  logic                            neg_q;
  logic [CNT_W-1:0]                cnt_q;
  logic                            m_valid_q;
  logic [itoar_pkg::CHAR_W-1:0]    m_char_q;
  logic                            m_last_q;

  itoar_pkg::ctrl_t                ctrl;
  itoar_pkg::fmt_e                 in_fmt;
  logic [itoar_pkg::ACTION_W-1:0]  in_action;
  logic [WORD_WIDTH-1:0]           in_value;
  logic                            in_fmt_ok;
  logic [CNT_W-1:0]                in_nd;
  logic                            s_acc;
  logic                            slot_free;
  logic [3:0]                      top_digit;

  assign in_action = s_axis_tdata_i[itoar_pkg::ACTION_W-1:0];
  assign in_value  = s_axis_tdata_i[itoar_pkg::ACTION_W +: WORD_WIDTH];
  assign in_fmt    = itoar_pkg::fmt_e'(in_action);
  assign in_fmt_ok = (in_action <= itoar_pkg::FMT_BIN);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !m_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;

  always_comb begin
    case (in_fmt)
      itoar_pkg::FMT_HEX_UP, itoar_pkg::FMT_HEX_LO: in_nd = CNT_W'(ND_HEX);
      itoar_pkg::FMT_OCT: in_nd = CNT_W'(ND_OCT);
      default:            in_nd = CNT_W'(WORD_WIDTH);
    endcase
  end

  always_comb begin
    ctrl.fmt = fmt_q;
    ctrl.op  = itoar_pkg::OP_HOLD;
    case (state_q)
      S_IDLE: begin
        ctrl.fmt = in_fmt;
        if (s_acc) begin
          ctrl.op = itoar_pkg::OP_LOAD;
        end
      end
      S_CONV: ctrl.op = itoar_pkg::OP_DABBLE;
      S_SKIP: begin
        if (top_digit == 4'd0 && cnt_q > CNT_W'(1)) begin
          ctrl.op = itoar_pkg::OP_SHIFT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ctrl.op = itoar_pkg::OP_SHIFT;
        end
      end
      default: ;
    endcase
  end

  itoar_shifter #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_shifter (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .value_i     (in_value),
    .top_digit_o (top_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fmt_q     <= itoar_pkg::FMT_DEC;
      neg_q     <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      // the sign and emit stages reload the slot on every transfer
      if (m_valid_q && m_axis_tready_i && state_q != S_SIGN && state_q != S_EMIT) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          // drop words with an unknown selector
          if (s_acc && in_fmt_ok) begin
            fmt_q <= in_fmt;
            neg_q <= (in_fmt == itoar_pkg::FMT_DEC) && in_value[WORD_WIDTH-1];
            if (in_fmt == itoar_pkg::FMT_DEC) begin
              cnt_q   <= CNT_W'(WORD_WIDTH);
              state_q <= S_CONV;
            end else begin
              cnt_q   <= in_nd;
              state_q <= S_SKIP;
            end
          end
        end
        S_CONV: begin
          if (cnt_q == CNT_W'(1)) begin
            cnt_q   <= CNT_W'(NDEC);
            state_q <= S_SKIP;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SKIP: begin
          // strip leading zeros, keep at least one digit
          if (top_digit == 4'd0 && cnt_q > CNT_W'(1)) begin
            cnt_q <= cnt_q - 1'b1;
          end else begin
            state_q <= neg_q ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            m_char_q  <= itoar_pkg::ASCII_MINUS;
            m_last_q  <= 1'b0;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            m_char_q  <= itoar_pkg::digit_char(top_digit, fmt_q);
            m_last_q  <= (cnt_q == CNT_W'(1));
            cnt_q     <= cnt_q - 1'b1;
            if (cnt_q == CNT_W'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // digit counter never runs dry while digits are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV || state_q == S_SKIP || state_q == S_EMIT) |-> (cnt_q != '0))
    else $error("digit counter empty while busy");

  // a sign is only produced for negative decimal words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN) |-> (neg_q && fmt_q == itoar_pkg::FMT_DEC))
    else $error("sign stage entered for a non-negative or non-decimal word");

  // the minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[6:0] == itoar_pkg::ASCII_MINUS) |-> !m_axis_tlast_o)
    else $error("minus sign flagged as last character");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives words with random format selectors into integer_to_ascii_radix and
// checks every character and tlast against an in-bench digit predictor,
// under random idle gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ACTION_W   = itoar_pkg::ACTION_W;
  localparam int unsigned CHAR_W     = itoar_pkg::CHAR_W;
  // selector codes past the last format are dropped by the block
  localparam int unsigned ACT_BAD_LO = int'(itoar_pkg::FMT_BIN) + 1;
  localparam int unsigned ACT_BAD_HI = (1 << ACTION_W) - 1;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [31:0]         word;
    bit                  calm;   // no gap after this word
    bit                  drain;  // hold until every character has come back
  } word_job_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  word_job_t   word_q[$];
  char_exp_t   char_q[$];
  word_job_t   job;
  char_exp_t   want;
  int unsigned gap_cnt;
  int unsigned stall_cnt;
  int unsigned mismatch_cnt = 0;
  bit          armed;
  bit          rx_calm;
  bit          all_done_q = 1'b1;

  integer_to_ascii_radix u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Spread word lengths: full random, small, small negative, and random words cut short
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom();
    end else if (r < 6) begin
      return $urandom_range(0, 255);
    end else if (r < 7) begin
      return {1'b1, 31'($urandom_range(0, 255))} | 32'h7FFFFF00;
    end
    return $urandom() >> $urandom_range(1, 31);
  endfunction

  // Expand one word into its characters, most significant first
  function automatic void predict_chars(input logic [ACTION_W-1:0] act,
                                        input logic [31:0] word);
    logic [31:0]       mag;
    logic [31:0]       digit;
    logic [CHAR_W-1:0] gap;
    logic [CHAR_W-1:0] chars[$];
    int unsigned       base;
    char_exp_t         e;
    bit                neg;
    mag  = word;
    gap  = '0;
    neg  = 1'b0;
    case (act)
      itoar_pkg::FMT_DEC: begin
        base = 10;
        if (word[31]) begin
          neg = 1'b1;
          mag = -word;
        end
      end
      itoar_pkg::FMT_HEX_UP: begin
        base = 16;
        gap  = itoar_pkg::UPPER_GAP;
      end
      itoar_pkg::FMT_HEX_LO: begin
        base = 16;
        gap  = itoar_pkg::LOWER_GAP;
      end
      itoar_pkg::FMT_OCT: base = 8;
      itoar_pkg::FMT_BIN: base = 2;
      default: return;
    endcase
    if (mag == 0) begin
      chars.push_front(itoar_pkg::ASCII_ZERO);
    end
    while (mag != 0) begin
      digit = mag % base;
      chars.push_front(itoar_pkg::ASCII_ZERO + CHAR_W'(digit) + ((digit > 9) ? gap : '0));
      mag = mag / base;
    end
    if (neg) begin
      chars.push_front(itoar_pkg::ASCII_MINUS);
    end
    foreach (chars[i]) begin
      e.code = chars[i];
      e.last = (i == chars.size() - 1);
      char_q.push_back(e);
    end
  endfunction

  task automatic note_mismatch(input string what, input char_exp_t exp_c,
                               input logic [7:0] got_data, input logic got_last);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: expected char %h last %b, got char %h last %b", $realtime,
               what, exp_c.code, exp_c.last, got_data[CHAR_W-1:0], got_last);
    end
  endtask

  // Driver: hold a word until its transfer, then draw the next gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      gap_cnt  <= 0;
      armed    <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (gap_cnt != 0) begin
        s_tvalid <= 1'b0;
        gap_cnt  <= gap_cnt - 1;
      end else if (word_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (word_q[0].drain && !(armed && all_done_q)) begin
        s_tvalid <= 1'b0;
        armed    <= 1'b1;
      end else begin
        job = word_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, job.word, job.act};
        gap_cnt  <= pick_gap(job.calm);
        armed    <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, with calm stretches toggled now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      stall_cnt <= 0;
      rx_calm   <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) begin
        rx_calm <= ~rx_calm;
      end
      if (stall_cnt != 0) begin
        m_tready  <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        m_tready  <= 1'b1;
        stall_cnt <= pick_gap(rx_calm);
      end
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        predict_chars(s_tdata[2:0], s_tdata[34:3]);
      end
      if (m_tvalid && m_tready) begin
        if (char_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected character", want, m_tdata, m_tlast);
        end else begin
          want = char_q.pop_front();
          if (m_tdata[CHAR_W-1:0] != want.code || m_tlast != want.last) begin
            note_mismatch("character mismatch", want, m_tdata, m_tlast);
          end
        end
      end
      all_done_q <= (char_q.size() == 0);
    end
  end

  task automatic add_word(input logic [ACTION_W-1:0] act, input logic [31:0] word,
                          input bit calm, input bit drain);
    word_job_t j;
    j.act   = act;
    j.word  = word;
    j.calm  = calm;
    j.drain = drain;
    word_q.push_back(j);
  endtask

  initial begin
    logic [31:0] corner[4];
    logic [ACTION_W-1:0] act;
    corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    rst_ni = 1'b0;

    // Directed: corner words in every format, all hex letters, bad selectors
    for (int f = itoar_pkg::FMT_DEC; f <= itoar_pkg::FMT_BIN; f++) begin
      foreach (corner[i]) begin
        add_word(ACTION_W'(f), corner[i], 1'b0, 1'b0);
      end
    end
    add_word(itoar_pkg::FMT_DEC, 32'd10, 1'b1, 1'b0);
    add_word(itoar_pkg::FMT_HEX_UP, 32'hFEDC_BA98, 1'b1, 1'b0);
    add_word(itoar_pkg::FMT_HEX_LO, 32'hFEDC_BA98, 1'b1, 1'b0);
    add_word(itoar_pkg::FMT_OCT, 32'd1, 1'b0, 1'b0);
    for (int a = ACT_BAD_LO; a <= ACT_BAD_HI; a++) begin
      add_word(ACTION_W'(a), $urandom(), 1'b0, 1'b0);
    end

    // Random part; drain before a few words so the output runs dry
    for (int n = 0; n < 395; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        act = ACTION_W'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
      end else begin
        act = ACTION_W'($urandom_range(itoar_pkg::FMT_DEC, itoar_pkg::FMT_BIN));
      end
      add_word(act, pick_word(), ((n / 40) % 4) == 1, n == 0 || n % 150 == 75);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(negedge clk_i);
    end while (word_q.size() != 0 || s_tvalid || !all_done_q);
    repeat (100) @(negedge clk_i);

    if (mismatch_cnt == 0 && char_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #64000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
